// ===== sv/srtn_pkg.sv =====
// Package with the shared types and constants of the scheduler.
`timescale 1ns / 1ps

package srtn_pkg;

    // Default size of the job table.
    localparam int MAX_JOBS_DEF = 16;

    // Field widths fixed by the word formats.
    localparam int BURST_W = 16;
    localparam int SLOT_W  = 4;
    localparam int TIME_W  = 32;
    localparam int QUANT_W = 8;

    // Quantum length after reset.
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd3;

    // Depth of the command queue between front and back.
    localparam int CMDQ_DEPTH = 2;

    // Input word.
    typedef struct packed {
        logic               mode;
        logic [BURST_W-1:0] burst_time;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [SLOT_W-1:0] running_slot;
        logic              idle;
        logic              completed;
        logic [SLOT_W-1:0] completed_slot;
        logic [TIME_W-1:0] current_time;
        logic              table_full;
        logic [SLOT_W-1:0] assigned_slot;
    } out_word_t;

    // Command kinds after classification.
    typedef enum logic {
        OP_ARRIVE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Command passed from front to back.
    typedef struct packed {
        op_t                op;
        logic [BURST_W-1:0] burst;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_WAIT,
        ST_RD,
        ST_DEC,
        ST_SCAN,
        ST_RD2,
        ST_DEC2,
        ST_DONE
    } back_state_t;

endpackage

// ===== sv/srtn_front.sv =====
// Input stage: accepts words and turns them into scheduler commands.
`timescale 1ns / 1ps

module srtn_front
    import srtn_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic valid_reg;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // Classify the incoming word by its mode bit.
    always_comb begin
        cmd_next.op    = s_data.mode ? OP_TICK : OP_ARRIVE;
        cmd_next.burst = s_data.burst_time;
    end

    // The stage takes a new word when empty or when its content moves on.
    assign s_ready = !valid_reg || cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== sv/srtn_cmd_fifo.sv =====
// Short command queue that decouples the front stage from the back end.
`timescale 1ns / 1ps

module srtn_cmd_fifo
    import srtn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int DEPTH = CMDQ_DEPTH;
    localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    cmd_t            store_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(DEPTH))
        else $error("command queue overfilled");

endmodule

// ===== sv/srtn_back.sv =====
// Back end: job table, scan comparator, sequencer and result register.
`timescale 1ns / 1ps

module srtn_back
    import srtn_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    input  logic               cfg_we,
    input  logic [QUANT_W-1:0] cfg_wdata,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data
);

    localparam int IDXW = $clog2(MAX_JOBS);
    localparam int CNTW = $clog2(MAX_JOBS + 1);
    localparam int EXTW = (IDXW > SLOT_W) ? IDXW : SLOT_W;

    // Sequencer and scheduling state.
    back_state_t        state_reg;
    back_state_t        state_next;
    logic [IDXW-1:0]    running_reg;
    logic [IDXW-1:0]    running_next;
    logic               idle_reg;
    logic               idle_next;
    logic [CNTW-1:0]    count_reg;
    logic [CNTW-1:0]    count_next;
    logic [QUANT_W-1:0] qu_reg;
    logic [QUANT_W-1:0] qu_next;
    logic [TIME_W-1:0]  tick_reg;
    logic [TIME_W-1:0]  tick_next;
    logic [QUANT_W-1:0] quant_reg;
    logic [MAX_JOBS-1:0] retired_reg;
    logic [MAX_JOBS-1:0] retired_next;

    // Scan state.
    logic [CNTW-1:0]    scan_cnt_reg;
    logic [CNTW-1:0]    scan_cnt_next;
    logic [IDXW-1:0]    best_idx_reg;
    logic [IDXW-1:0]    best_idx_next;
    logic [BURST_W-1:0] best_val_reg;
    logic [BURST_W-1:0] best_val_next;
    logic               found_reg;
    logic               found_next;
    logic               scan_cmpl_reg;
    logic               scan_cmpl_next;

    // Per-word result fields.
    logic               compl_reg;
    logic               compl_next;
    logic [IDXW-1:0]    cslot_reg;
    logic [IDXW-1:0]    cslot_next;
    logic               tfull_reg;
    logic               tfull_next;
    logic [IDXW-1:0]    aslot_reg;
    logic [IDXW-1:0]    aslot_next;

    // Remaining-time memory.
    logic [BURST_W-1:0] rem_mem [MAX_JOBS];
    logic [BURST_W-1:0] rd_data_reg;
    logic [IDXW-1:0]    rd_addr;
    logic               wr_en;
    logic [IDXW-1:0]    wr_addr;
    logic [BURST_W-1:0] wr_data;

    // Result register.
    logic               m_valid_reg;
    out_word_t          m_data_reg;
    out_word_t          result;
    logic               out_free;
    logic               out_load;

    // Scan comparator signals.
    logic [IDXW-1:0]    eval_idx;
    logic               eval_live;
    logic               take;
    logic               sel_found;
    logic [IDXW-1:0]    sel_idx;
    logic [BURST_W-1:0] sel_val;
    logic [QUANT_W:0]   qu_inc;
    logic [EXTW-1:0]    run_ext;
    logic [EXTW-1:0]    cslot_ext;
    logic [EXTW-1:0]    aslot_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign qu_inc   = {1'b0, qu_reg} + 1'b1;

    // One table entry is judged per scan cycle, in the cycle after its read.
    always_comb begin
        eval_idx  = IDXW'(scan_cnt_reg - 1'b1);
        eval_live = (scan_cnt_reg != '0) && (CNTW'(eval_idx) < count_reg)
                    && !retired_reg[eval_idx];
        take      = eval_live && (!found_reg || (rd_data_reg < best_val_reg));
        sel_found = found_reg || take;
        sel_idx   = take ? eval_idx : best_idx_reg;
        sel_val   = take ? rd_data_reg : best_val_reg;
    end

    // Result word built from the state after the item.
    always_comb begin
        run_ext   = EXTW'(running_reg);
        cslot_ext = EXTW'(cslot_reg);
        aslot_ext = EXTW'(aslot_reg);
        result.running_slot   = idle_reg ? '0 : run_ext[SLOT_W-1:0];
        result.idle           = idle_reg;
        result.completed      = compl_reg;
        result.completed_slot = cslot_ext[SLOT_W-1:0];
        result.current_time   = tick_reg;
        result.table_full     = tfull_reg;
        result.assigned_slot  = aslot_ext[SLOT_W-1:0];
    end

    // Sequencer: next state, table updates and memory port control.
    always_comb begin
        state_next     = state_reg;
        running_next   = running_reg;
        idle_next      = idle_reg;
        count_next     = count_reg;
        qu_next        = qu_reg;
        tick_next      = tick_reg;
        retired_next   = retired_reg;
        scan_cnt_next  = scan_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        found_next     = found_reg;
        scan_cmpl_next = scan_cmpl_reg;
        compl_next     = compl_reg;
        cslot_next     = cslot_reg;
        tfull_next     = tfull_reg;
        aslot_next     = aslot_reg;
        rd_addr        = running_reg;
        wr_en          = 1'b0;
        wr_addr        = running_reg;
        wr_data        = rd_data_reg - 1'b1;
        cmd_ready      = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_WAIT: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    compl_next = 1'b0;
                    cslot_next = '0;
                    tfull_next = 1'b0;
                    aslot_next = '0;
                    state_next = ST_DONE;
                    if (cmd.op == OP_ARRIVE) begin
                        if (count_reg == CNTW'(MAX_JOBS)) begin
                            tfull_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[IDXW-1:0];
                            wr_data    = cmd.burst;
                            retired_next[count_reg[IDXW-1:0]] = 1'b0;
                            count_next = count_reg + 1'b1;
                            aslot_next = count_reg[IDXW-1:0];
                            if (idle_reg) begin
                                running_next = count_reg[IDXW-1:0];
                                idle_next    = 1'b0;
                                qu_next      = '0;
                            end
                        end
                    end else begin
                        tick_next = tick_reg + 1'b1;
                        if (!idle_reg) begin
                            state_next = ST_RD;
                        end
                    end
                end
            end

            ST_RD: begin
                state_next = ST_DEC;
            end

            ST_DEC: begin
                scan_cnt_next = '0;
                found_next    = 1'b0;
                if (rd_data_reg == '0) begin
                    // Running job is finished: retire it and pick another.
                    retired_next[running_reg] = 1'b1;
                    compl_next     = 1'b1;
                    cslot_next     = running_reg;
                    scan_cmpl_next = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    wr_en = 1'b1;
                    if (qu_inc >= {1'b0, quant_reg}) begin
                        scan_cmpl_next = 1'b0;
                        state_next     = ST_SCAN;
                    end else begin
                        qu_next    = qu_inc[QUANT_W-1:0];
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN: begin
                rd_addr       = scan_cnt_reg[IDXW-1:0];
                found_next    = sel_found;
                best_idx_next = sel_idx;
                best_val_next = sel_val;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CNTW'(MAX_JOBS)) begin
                    qu_next = '0;
                    if (sel_found) begin
                        running_next = sel_idx;
                        idle_next    = 1'b0;
                        state_next   = scan_cmpl_reg ? ST_RD2 : ST_DONE;
                    end else begin
                        running_next = '0;
                        idle_next    = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end

            ST_RD2: begin
                state_next = ST_DEC2;
            end

            ST_DEC2: begin
                // Newly chosen job runs this tick; a zero count stays zero.
                wr_en      = (rd_data_reg != '0);
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_WAIT;
                end
            end

            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WAIT;
            running_reg <= '0;
            idle_reg    <= 1'b1;
            count_reg   <= '0;
            qu_reg      <= '0;
            tick_reg    <= '0;
            retired_reg <= '0;
            quant_reg   <= QUANTUM_RESET;
            m_valid_reg <= 1'b0;
            scan_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            idle_reg    <= idle_next;
            count_reg   <= count_next;
            qu_reg      <= qu_next;
            tick_reg    <= tick_next;
            retired_reg <= retired_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_we) begin
                quant_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers without reset.
    always_ff @(posedge aclk) begin
        best_idx_reg  <= best_idx_next;
        best_val_reg  <= best_val_next;
        found_reg     <= found_next;
        scan_cmpl_reg <= scan_cmpl_next;
        compl_reg     <= compl_next;
        cslot_reg     <= cslot_next;
        tfull_reg     <= tfull_next;
        aslot_reg     <= aslot_next;
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    // Remaining-time memory with registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rem_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= rem_mem[rd_addr];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // While idle the running index is parked at zero.
    a_idle_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg |-> (running_reg == '0))
        else $error("running index not cleared while idle");

    // Between items a running job is an arrived job that has not retired.
    a_running_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && !idle_reg) |->
            (!retired_reg[running_reg] && (CNTW'(running_reg) < count_reg)))
        else $error("running job is not live");

    // The arrival count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(MAX_JOBS))
        else $error("arrival count overflow");

    // A scan never runs past the last table entry.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNTW'(MAX_JOBS)))
        else $error("scan counter out of range");

endmodule

// ===== sv/srtn_quantum_scheduler.sv =====
// An arrival or idle tick word passes the front stage, the command queue and the back-end wait
// and done states; a tick that keeps its job adds the read and decrement states, one that
// reselects adds the table scan, and a hand-over adds the second read and decrement states.
// The back end takes a new command only in its wait state; the scan judges one entry per cycle.
// Reset (aresetn, synchronous, active low) clears all control state and sets the
// quantum to 3; the remaining-time memory is not cleared and is only read once written.
`timescale 1ns / 1ps

module srtn_quantum_scheduler
    import srtn_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    input  logic               cfg_we,
    input  logic [QUANT_W-1:0] cfg_wdata
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Front stage classifies incoming words.
    srtn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // Command queue between the two halves.
    srtn_cmd_fifo u_cmd_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    // Back end runs the job table and produces result words.
    srtn_back #(
        .MAX_JOBS (MAX_JOBS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the shortest-remaining-time scheduler with quantum.
`timescale 1ns / 1ps

module testbench;
    import srtn_pkg::*;

    localparam int JOBS = MAX_JOBS_DEF;
    // Cycles to let the block settle before a quantum write and at the end.
    localparam int SETTLE = JOBS + 16;
    // Long receiver hold-off that makes the block back up its input.
    localparam int HOLD_OFF = 400;
    localparam int HOLD_AT_RESULT = 300;
    localparam int PHASE_ITEMS = 400;

    typedef enum logic [1:0] {
        ENT_WORD,
        ENT_DRAIN,
        ENT_CFG
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t        kind;
        in_word_t           word;
        logic [QUANT_W-1:0] quantum;
        logic [2:0]         gap;
    } stim_entry_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_word_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               cfg_we = 1'b0;
    logic [QUANT_W-1:0] cfg_wdata = '0;

    stim_entry_t pending_words[$];
    out_word_t   sched_results[$];

    logic        word_taken = 1'b0;
    logic        result_taken = 1'b0;
    logic        stim_done = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned gap_left = 0;
    int unsigned settle_left = SETTLE;
    int unsigned stall_left = 0;
    int unsigned words_queued = 0;
    logic        quiet_sender = 1'b0;

    // Scheduler state kept by the predictor.
    logic [BURST_W-1:0] job_left [JOBS];
    logic               job_done [JOBS];
    int unsigned        jobs_arrived = 0;
    int unsigned        run_slot = 0;
    int unsigned        quantum_used = 0;
    logic [TIME_W-1:0]  tick_now = '0;
    logic               sched_idle = 1'b1;
    logic [QUANT_W-1:0] quantum_setting = QUANTUM_RESET;

    srtn_quantum_scheduler #(
        .MAX_JOBS (JOBS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Choose the live job with the least remaining time; the lowest slot wins a tie.
    function automatic void pick_shortest();
        logic        found;
        int unsigned best;
        found = 1'b0;
        best = 0;
        for (int unsigned i = 0; i < jobs_arrived && i < JOBS; i++) begin
            if (!job_done[i] && (!found || job_left[i] < job_left[best])) begin
                best = i;
                found = 1'b1;
            end
        end
        sched_idle = !found;
        run_slot = found ? best : 0;
    endfunction

    // Advance the scheduler by one input word and return the word it reports.
    function automatic out_word_t sched_step(in_word_t w);
        out_word_t   r;
        logic        done_now;
        int unsigned slot;
        r = '0;
        done_now = 1'b0;
        if (w.mode == OP_ARRIVE) begin
            if (jobs_arrived >= JOBS) begin
                r.table_full = 1'b1;
            end else begin
                slot = jobs_arrived;
                job_left[slot] = w.burst_time;
                job_done[slot] = 1'b0;
                jobs_arrived++;
                r.assigned_slot = SLOT_W'(slot);
                if (sched_idle) begin
                    run_slot = slot;
                    sched_idle = 1'b0;
                    quantum_used = 0;
                end
            end
        end else begin
            if (!sched_idle) begin
                // A job already at zero retires before any service is given.
                if (job_left[run_slot] == '0) begin
                    job_done[run_slot] = 1'b1;
                    done_now = 1'b1;
                    r.completed_slot = SLOT_W'(run_slot);
                    pick_shortest();
                end
                if (!sched_idle) begin
                    if (!job_done[run_slot] && job_left[run_slot] != '0) begin
                        job_left[run_slot] = job_left[run_slot] - 1'b1;
                    end
                    quantum_used++;
                end
            end
            tick_now = tick_now + 1'b1;
            if (done_now || (!sched_idle && quantum_used >= quantum_setting)) begin
                pick_shortest();
                quantum_used = 0;
            end
            if (sched_idle) begin
                quantum_used = 0;
            end
        end
        r.running_slot = sched_idle ? '0 : SLOT_W'(run_slot);
        r.idle = sched_idle;
        r.completed = done_now;
        r.current_time = tick_now;
        return r;
    endfunction

    task automatic push_word(op_t op, logic [BURST_W-1:0] burst);
        stim_entry_t e;
        // Sender gaps come in stretches, some of them with no gaps at all.
        if (words_queued % 64 == 0) begin
            quiet_sender = ($urandom_range(0, 3) == 0);
        end
        e = '0;
        e.kind = ENT_WORD;
        e.word.mode = op;
        e.word.burst_time = burst;
        e.gap = quiet_sender ? 3'd0 : 3'($urandom_range(0, 7));
        pending_words.push_back(e);
        words_queued++;
    endtask

    task automatic push_marker(entry_kind_t kind, logic [QUANT_W-1:0] value);
        stim_entry_t e;
        e = '0;
        e.kind = kind;
        e.quantum = value;
        pending_words.push_back(e);
    endtask

    // Sender: launches queued words, pauses for drains and quantum writes.
    always @(negedge aclk) begin
        logic next_valid;
        logic next_we;
        next_valid = 1'b0;
        next_we = 1'b0;
        if (aresetn) begin
            if (s_valid && !word_taken) begin
                next_valid = 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (pending_words.size() == 0) begin
                stim_done <= 1'b1;
            end else begin
                case (pending_words[0].kind)
                    ENT_WORD: begin
                        next_valid = 1'b1;
                        s_data <= pending_words[0].word;
                        gap_left = pending_words[0].gap;
                        void'(pending_words.pop_front());
                    end
                    ENT_DRAIN: begin
                        if (sched_results.size() == 0) begin
                            void'(pending_words.pop_front());
                        end
                    end
                    default: begin
                        // The quantum is only written once the block has gone quiet.
                        if (sched_results.size() != 0) begin
                            settle_left = SETTLE;
                        end else if (settle_left != 0) begin
                            settle_left--;
                        end else begin
                            next_we = 1'b1;
                            cfg_wdata <= pending_words[0].quantum;
                            settle_left = SETTLE;
                            void'(pending_words.pop_front());
                        end
                    end
                endcase
            end
            s_valid <= next_valid;
            cfg_we <= next_we;
        end
    end

    // Receiver: random stalls per result, quiet stretches, and one long hold-off.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (result_taken) begin
                results_seen++;
                if (results_seen == HOLD_AT_RESULT) begin
                    stall_left = HOLD_OFF;
                end else if ((results_seen / 50) % 4 == 0) begin
                    stall_left = 0;
                end else begin
                    stall_left = $urandom_range(0, 7);
                end
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: checks each result word, then predicts for each accepted input word.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (cfg_we) begin
                quantum_setting = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (sched_results.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    want = sched_results.pop_front();
                    check_field("running_slot", 32'(m_data.running_slot), 32'(want.running_slot));
                    check_field("idle", 32'(m_data.idle), 32'(want.idle));
                    check_field("completed", 32'(m_data.completed), 32'(want.completed));
                    check_field("completed_slot", 32'(m_data.completed_slot),
                                32'(want.completed_slot));
                    check_field("current_time", m_data.current_time, want.current_time);
                    check_field("table_full", 32'(m_data.table_full), 32'(want.table_full));
                    check_field("assigned_slot", 32'(m_data.assigned_slot),
                                32'(want.assigned_slot));
                end
            end
            if (s_valid && s_ready) begin
                sched_results.push_back(sched_step(s_data));
            end
            word_taken <= s_valid && s_ready;
            result_taken <= m_valid && m_ready;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [QUANT_W-1:0] phase_quantum [4];
        int unsigned        pick;
        logic [BURST_W-1:0] burst;

        for (int i = 0; i < JOBS; i++) begin
            job_done[i] = 1'b0;
        end

        // Directed: idle tick, zero bursts, the largest burst, a tie and a quantum expiry.
        push_word(OP_TICK, 16'hFFFF);
        push_word(OP_ARRIVE, 16'd0);
        push_word(OP_TICK, 16'd0);
        push_word(OP_TICK, 16'h5555);
        push_word(OP_ARRIVE, 16'hFFFF);
        push_word(OP_ARRIVE, 16'd0);
        push_word(OP_ARRIVE, 16'd0);
        for (int i = 0; i < 5; i++) begin
            push_word(OP_TICK, 16'hAAAA);
        end
        push_word(OP_ARRIVE, 16'd2);
        push_word(OP_ARRIVE, 16'd2);
        for (int i = 0; i < 8; i++) begin
            push_word(OP_TICK, 16'd0);
        end

        // Random phases, each under its own quantum setting.
        phase_quantum[0] = 8'd1;
        phase_quantum[1] = 8'd255;
        phase_quantum[2] = 8'd0;
        phase_quantum[3] = 8'($urandom_range(2, 254));
        for (int p = 0; p < 4; p++) begin
            push_marker(ENT_CFG, phase_quantum[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2) begin
                        burst = 16'($urandom_range(0, 3));
                    end else if (pick < 9) begin
                        burst = 16'($urandom_range(0, 40));
                    end else begin
                        burst = 16'($urandom_range(0, 65535));
                    end
                    push_word(OP_ARRIVE, burst);
                end else begin
                    push_word(OP_TICK, 16'($urandom_range(0, 65535)));
                end
                if (p == 1 && n == PHASE_ITEMS / 2) begin
                    push_marker(ENT_DRAIN, '0);
                end
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (!stim_done || sched_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && sched_results.size() == 0) begin
            $display("** srtn_quantum_scheduler: PASSED **");
        end else begin
            $display("** srtn_quantum_scheduler: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5ms;
        $display("** srtn_quantum_scheduler: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/srtn_pkg.sv
sv/srtn_front.sv
sv/srtn_cmd_fifo.sv
sv/srtn_back.sv
sv/srtn_quantum_scheduler.sv
tb/testbench.sv
